/* rtl/fcr_pkg.sv */
package fcr_pkg;

  // Field widths
  localparam int unsigned CompW   = 24;  // Q8.16 vector component
  localparam int unsigned UnitW   = 32;  // Q1.30 unit component, signed
  localparam int unsigned CfgW    = 24;  // eta / kappa, unsigned Q8.16
  localparam int unsigned ReflW   = 17;  // Q1.16 result
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRefrIndex = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAbsorption = 1'b1;

  // Register reset values
  localparam logic [CfgW-1:0] RefrIndexRst = 24'd65536;
  localparam logic [CfgW-1:0] AbsorptionRst = 24'd0;

  // Pipeline depths
  localparam int unsigned SqrtSteps  = 31;  // one root bit per stage
  localparam int unsigned DivSteps   = 31;  // one quotient bit per stage
  localparam int unsigned RatioSteps = 40;  // Q.16 ratio, 40 quotient bits
  localparam int unsigned NormLat    = 3 + SqrtSteps + 1 + DivSteps + 1;
  localparam int unsigned RatioLat   = 1 + RatioSteps + 1;
  localparam int unsigned ShadeLat   = 8 + RatioLat + 3;
  localparam int unsigned TotalLat   = NormLat + ShadeLat;

  // Raw input vector, element 0 is x
  typedef logic [2:0][CompW-1:0] vec_t;

  // Normalized vector with zero-length flag
  typedef struct packed {
    logic [2:0][UnitW-1:0] u;
    logic                  zero;
  } unit_t;

endpackage

/* rtl/fcr_norm.sv */
// Vector normalizer: squared length, pipelined integer square root,
// then a shared-divisor restoring divider for the three components.
module fcr_norm import fcr_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  vec_t  vec_i,
  output unit_t unit_o
);

  // Stage 0: magnitudes and signs
  logic [2:0][23:0] mag_d, mag_q;
  logic [2:0]       sgn_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][23] ? 24'(-vec_i[i]) : vec_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      for (int i = 0; i < 3; i++) sgn_q[i] <= vec_i[i][23];
    end
  end

  // Stage 1: squares
  logic [2:0][47:0] sq_q;
  logic [2:0][23:0] mag1_q;
  logic [2:0]       sgn1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= mag_q[i] * mag_q[i];
      mag1_q <= mag_q;
      sgn1_q <= sgn_q;
    end
  end

  // Stage 2: squared length, scaled for a Q.23 root
  logic [49:0] len2;
  assign len2 = {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]};

  logic [61:0]      sv_q   [SqrtSteps+1];
  logic [61:0]      sr_q   [SqrtSteps+1];
  logic [2:0][23:0] smag_q [SqrtSteps+1];
  logic [2:0]       ssgn_q [SqrtSteps+1];
  logic             szero_q[SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q[0]    <= {len2[47:0], 14'b0};
      sr_q[0]    <= '0;
      smag_q[0]  <= mag1_q;
      ssgn_q[0]  <= sgn1_q;
      szero_q[0] <= (len2 == '0);
    end
  end

  // Square root, one bit pair per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [61:0] Bit = 62'(1) << (60 - 2*k);
    logic [62:0] t;
    logic        ge;
    assign t  = {1'b0, sr_q[k]} + {1'b0, Bit};
    assign ge = ({1'b0, sv_q[k]} >= t);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sv_q[k+1]    <= ge ? 62'({1'b0, sv_q[k]} - t) : sv_q[k];
        sr_q[k+1]    <= ge ? (sr_q[k] >> 1) + Bit : sr_q[k] >> 1;
        smag_q[k+1]  <= smag_q[k];
        ssgn_q[k+1]  <= ssgn_q[k];
        szero_q[k+1] <= szero_q[k];
      end
    end
  end

  // Divider setup: dividend is mag << 37, its low 31 bits are zero
  logic [30:0]      dd_q   [DivSteps+1];
  logic [2:0][30:0] drem_q [DivSteps+1];
  logic [2:0][30:0] dquo_q [DivSteps+1];
  logic [2:0]       dsgn_q [DivSteps+1];
  logic             dzero_q[DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q[0] <= sr_q[SqrtSteps][30:0];
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= {1'b0, smag_q[SqrtSteps][i], 6'b0};
        dquo_q[0][i] <= '0;
      end
      dsgn_q[0]  <= ssgn_q[SqrtSteps];
      dzero_q[0] <= szero_q[SqrtSteps];
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [2:0][31:0] sh;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {drem_q[j][i], 1'b0};
        ge[i] = (sh[i] >= {1'b0, dd_q[j]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dd_q[j+1] <= dd_q[j];
        for (int i = 0; i < 3; i++) begin
          drem_q[j+1][i] <= ge[i] ? 31'(sh[i] - {1'b0, dd_q[j]}) : sh[i][30:0];
          dquo_q[j+1][i] <= {dquo_q[j][i][29:0], ge[i]};
        end
        dsgn_q[j+1]  <= dsgn_q[j];
        dzero_q[j+1] <= dzero_q[j];
      end
    end
  end

  // Apply signs
  unit_t unit_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        unit_q.u[i] <= dsgn_q[DivSteps][i] ? 32'(-{1'b0, dquo_q[DivSteps][i]})
                                           : {1'b0, dquo_q[DivSteps][i]};
      end
      unit_q.zero <= dzero_q[DivSteps];
    end
  end

  assign unit_o = unit_q;

endmodule

/* rtl/fcr_ratio.sv */
// Pipelined ratio floor(num * 2^16 / den), saturating to 2^40.
module fcr_ratio import fcr_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [49:0] num_i,
  input  logic [45:0] den_i,
  output logic [40:0] quo_o
);

  logic [45:0] rem_q [RatioSteps+1];
  logic [39:0] low_q [RatioSteps+1];  // dividend bits in, quotient bits out
  logic [45:0] den_q [RatioSteps+1];
  logic        sat_q [RatioSteps+1];

  // Setup: integer part >= 2^24 saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {20'b0, num_i[49:24]};
      low_q[0] <= {num_i[23:0], 16'b0};
      den_q[0] <= den_i;
      sat_q[0] <= ({20'b0, num_i[49:24]} >= den_i);
    end
  end

  for (genvar j = 0; j < RatioSteps; j++) begin : g_step
    logic [46:0] sh;
    logic        ge;
    assign sh = {rem_q[j], low_q[j][39]};
    assign ge = (sh >= {1'b0, den_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? 46'(sh - {1'b0, den_q[j]}) : sh[45:0];
        low_q[j+1] <= {low_q[j][38:0], ge};
        den_q[j+1] <= den_q[j];
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  logic [40:0] quo_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= sat_q[RatioSteps] ? (41'(1) << 40) : {1'b0, low_q[RatioSteps]};
    end
  end

  assign quo_o = quo_q;

endmodule

/* rtl/fcr_shade.sv */
// Cosines, conductor Fresnel terms, their average and the cosine weight.
module fcr_shade import fcr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  unit_t            n_i,
  input  unit_t            v_i,
  input  unit_t            l_i,
  input  logic [CfgW-1:0]  refr_index_i,
  input  logic [CfgW-1:0]  absorption_i,
  output logic [ReflW-1:0] refl_o,
  output logic             degen_o
);

  typedef struct packed {
    logic [49:0] n;
    logic [45:0] d;
  } pair_t;

  // |dot| of Q1.30 vectors rounded to Q.16, clamped to one
  function automatic logic [16:0] cos_mag(input logic [63:0] d);
    logic [63:0] mag;
    logic [64:0] s;
    logic [20:0] m;
    mag = d[63] ? 64'(-d) : d;
    s   = {1'b0, mag} + (65'(1) << 43);
    m   = s[64:44];
    return (m > 21'd65536) ? 17'd65536 : m[16:0];
  endfunction

  // Clamp numerator, scale both until the denominator is below 2^46
  function automatic pair_t scale(input logic [51:0] num, input logic [51:0] den);
    logic [49:0] n;
    logic [49:0] d;
    logic [2:0]  s;
    pair_t       r;
    n = num[51] ? '0 : num[49:0];
    d = den[49:0];
    priority if (d[49]) s = 3'd4;
    else if (d[48])     s = 3'd3;
    else if (d[47])     s = 3'd2;
    else if (d[46])     s = 3'd1;
    else                s = 3'd0;
    n   = n >> s;
    d   = d >> s;
    r.n = n;
    r.d = d[45:0];
    return r;
  endfunction

  // h0: component products, eta^2 and kappa^2
  logic signed [2:0][63:0] pl_d, pv_d, pl_q, pv_q;
  logic [47:0] ee_q, kk_q;
  logic        bad0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pl_d[i] = $signed(l_i.u[i]) * $signed(n_i.u[i]);
      pv_d[i] = $signed(v_i.u[i]) * $signed(n_i.u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= pl_d;
      pv_q   <= pv_d;
      ee_q   <= refr_index_i * refr_index_i;
      kk_q   <= absorption_i * absorption_i;
      bad0_q <= n_i.zero | v_i.zero | l_i.zero;
    end
  end

  // h1: dot products, eta^2 + kappa^2
  logic [63:0] dl_q, dv_q;
  logic [48:0] e32_1_q;
  logic        bad1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q    <= pl_q[0] + pl_q[1] + pl_q[2];
      dv_q    <= pv_q[0] + pv_q[1] + pv_q[2];
      e32_1_q <= {1'b0, ee_q} + {1'b0, kk_q};
      bad1_q  <= bad0_q;
    end
  end

  // h2: cosines in Q.16, e16
  logic [16:0]        clm;
  logic signed [17:0] cl_q;
  logic [16:0]        cvm2_q;
  logic [49:0]        es;
  logic [33:0]        e16_q;
  logic [48:0]        e32_2_q;
  logic               bad2_q;

  assign clm = cos_mag(dl_q);
  assign es  = {1'b0, e32_1_q} + 50'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cl_q    <= dl_q[63] ? 18'(-{1'b0, clm}) : {1'b0, clm};
      cvm2_q  <= cos_mag(dv_q);
      e16_q   <= es[49:16];
      e32_2_q <= e32_1_q;
      bad2_q  <= bad1_q;
    end
  end

  // h3: c^2 and 2 eta c
  logic signed [35:0] csq;
  logic signed [42:0] ec;
  logic [32:0]        c2w_q;
  logic [43:0]        tmp_q;
  logic [33:0]        e16_3_q;
  logic [48:0]        e32_3_q;
  logic [16:0]        cvm3_q;
  logic               bad3_q;

  assign csq = cl_q * cl_q;
  assign ec  = $signed({1'b0, refr_index_i}) * cl_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2w_q   <= csq[32:0];
      tmp_q   <= {ec, 1'b0};
      e16_3_q <= e16_q;
      e32_3_q <= e32_2_q;
      cvm3_q  <= cvm2_q;
      bad3_q  <= bad2_q;
    end
  end

  // h4: c^2 rounded to Q.16
  logic [33:0] cs;
  logic [16:0] c2n_q;
  logic [32:0] c2w_4_q;
  logic [43:0] tmp_4_q;
  logic [33:0] e16_4_q;
  logic [48:0] e32_4_q;
  logic [16:0] cvm4_q;
  logic        bad4_q;

  assign cs = {1'b0, c2w_q} + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2n_q   <= cs[32:16];
      c2w_4_q <= c2w_q;
      tmp_4_q <= tmp_q;
      e16_4_q <= e16_3_q;
      e32_4_q <= e32_3_q;
      cvm4_q  <= cvm3_q;
      bad4_q  <= bad3_q;
    end
  end

  // h5: e16 * c2_16
  logic [50:0] p_q;
  logic [43:0] tmp_5_q;
  logic [48:0] e32_5_q;
  logic [32:0] c2w_5_q;
  logic [16:0] cvm5_q;
  logic        bad5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= e16_4_q * c2n_q;
      tmp_5_q <= tmp_4_q;
      e32_5_q <= e32_4_q;
      c2w_5_q <= c2w_4_q;
      cvm5_q  <= cvm4_q;
      bad5_q  <= bad4_q;
    end
  end

  // h6: numerators and denominators in Q.32
  localparam logic signed [51:0] One32 = 52'h1_0000_0000;
  logic signed [51:0] p_s, t_s, e_s, c_s;
  logic signed [51:0] np_q, dp_q, nb_q, db_q;
  logic [16:0]        cvm6_q;
  logic               bad6_q;

  assign p_s = $signed({1'b0, p_q});
  assign t_s = $signed({{8{tmp_5_q[43]}}, tmp_5_q});
  assign e_s = $signed({3'b0, e32_5_q});
  assign c_s = $signed({19'b0, c2w_5_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      np_q   <= p_s - t_s + One32;
      dp_q   <= p_s + t_s + One32;
      nb_q   <= e_s - t_s + c_s;
      db_q   <= e_s + t_s + c_s;
      cvm6_q <= cvm5_q;
      bad6_q <= bad5_q;
    end
  end

  // h7: denominator check, scaling for the dividers
  pair_t pa, pb, pa_q, pb_q;
  logic  den_bad;
  logic [16:0] cvm7_q;
  logic        bad7_q;

  assign pa      = scale(np_q, dp_q);
  assign pb      = scale(nb_q, db_q);
  assign den_bad = dp_q[51] | (dp_q == '0) | db_q[51] | (db_q == '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa;
      pb_q   <= pb;
      cvm7_q <= cvm6_q;
      bad7_q <= bad6_q | den_bad;
    end
  end

  // Two ratio dividers
  logic [40:0] ra, rb;

  fcr_ratio u_ratio_par (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (pa_q.n),
    .den_i (pa_q.d),
    .quo_o (ra)
  );

  fcr_ratio u_ratio_perp (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (pb_q.n),
    .den_i (pb_q.d),
    .quo_o (rb)
  );

  // Sideband alongside the dividers
  logic [16:0] scvm_q[RatioLat];
  logic        sbad_q[RatioLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scvm_q[0] <= cvm7_q;
      sbad_q[0] <= bad7_q;
      for (int k = 1; k < RatioLat; k++) begin
        scvm_q[k] <= scvm_q[k-1];
        sbad_q[k] <= sbad_q[k-1];
      end
    end
  end

  // Average, weight by |cos V|, round and saturate
  logic [41:0] rsum;
  logic [40:0] avg_q;
  logic [16:0] cvm8_q;
  logic        bad8_q;
  logic [57:0] prod_q;
  logic        bad9_q;
  logic [58:0] rnd;
  logic [42:0] res;
  logic [ReflW-1:0] refl_q;
  logic             degen_q;

  assign rsum = {1'b0, ra} + {1'b0, rb};
  assign rnd  = {1'b0, prod_q} + 59'd32768;
  assign res  = rnd[58:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      avg_q   <= rsum[41:1];
      cvm8_q  <= scvm_q[RatioLat-1];
      bad8_q  <= sbad_q[RatioLat-1];
      prod_q  <= avg_q * cvm8_q;
      bad9_q  <= bad8_q;
      degen_q <= bad9_q;
      if (bad9_q) begin
        refl_q <= '0;
      end else if (res > 43'd65536) begin
        refl_q <= 17'd65536;
      end else begin
        refl_q <= res[16:0];
      end
    end
  end

  assign refl_o  = refl_q;
  assign degen_o = degen_q;

endmodule

/* rtl/fresnel_conductor_reflectance.sv */
// Grey conductor Fresnel reflectance weight. Each transfer carries a surface
// normal, an outgoing and an incoming direction (signed Q8.16); the block
// normalizes them, evaluates the averaged parallel/perpendicular conductor
// Fresnel terms for the configured eta and kappa at cos(L,N), and scales by
// |cos(V,N)|, giving a Q1.16 weight in 0..1. A zero-length vector or a
// non-positive Fresnel denominator gives 0 with degenerate set. The pipeline
// takes one item every clock unless the output stalls; its depth is set by
// the bit-per-stage square root and component divider (62 stages) and the
// 40-bit ratio dividers. Output stall freezes the whole pipeline while a
// result waits. Write eta/kappa only with the pipeline empty.
module fresnel_conductor_reflectance import fcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CompW-1:0]   normal_x_i,
  input  logic [CompW-1:0]   normal_y_i,
  input  logic [CompW-1:0]   normal_z_i,
  input  logic [CompW-1:0]   view_x_i,
  input  logic [CompW-1:0]   view_y_i,
  input  logic [CompW-1:0]   view_z_i,
  input  logic [CompW-1:0]   light_x_i,
  input  logic [CompW-1:0]   light_y_i,
  input  logic [CompW-1:0]   light_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ReflW-1:0]   reflectance_o,
  output logic               degenerate_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [CfgW-1:0] refr_index_d, refr_index_q;
  logic [CfgW-1:0] absorption_d, absorption_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    refr_index_d = refr_index_q;
    absorption_d = absorption_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRefrIndex:  refr_index_d = cfg_data_i;
        CfgAbsorption: absorption_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_index_q <= RefrIndexRst;
      absorption_q <= AbsorptionRst;
    end else begin
      refr_index_q <= refr_index_d;
      absorption_q <= absorption_d;
    end
  end

  // Global advance: hold everything while the finished result is stalled
  logic                en;
  logic [TotalLat-1:0] vld_d, vld_q;

  assign en         = !(vld_q[TotalLat-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[TotalLat-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Normalizers
  vec_t  n_vec, v_vec, l_vec;
  unit_t n_unit, v_unit, l_unit;

  assign n_vec = {normal_z_i, normal_y_i, normal_x_i};
  assign v_vec = {view_z_i, view_y_i, view_x_i};
  assign l_vec = {light_z_i, light_y_i, light_x_i};

  fcr_norm u_norm_n (.clk_i(clk_i), .en_i(en), .vec_i(n_vec), .unit_o(n_unit));
  fcr_norm u_norm_v (.clk_i(clk_i), .en_i(en), .vec_i(v_vec), .unit_o(v_unit));
  fcr_norm u_norm_l (.clk_i(clk_i), .en_i(en), .vec_i(l_vec), .unit_o(l_unit));

  // Fresnel evaluation
  fcr_shade u_shade (
    .clk_i        (clk_i),
    .en_i         (en),
    .n_i          (n_unit),
    .v_i          (v_unit),
    .l_i          (l_unit),
    .refr_index_i (refr_index_q),
    .absorption_i (absorption_q),
    .refl_o       (reflectance_o),
    .degen_o      (degenerate_o)
  );

  assign out_valid_o = vld_q[TotalLat-1];

endmodule
